/* rtl/rwkc_pkg.sv */
// ----------------------------------------------------------------------------
// rwkc_pkg
// Shared types and constants for the rolling window key counter.
// ----------------------------------------------------------------------------
package rwkc_pkg;

   localparam int ENTRIES_DEF     = 64;
   localparam int CHUNKS_DEF      = 5;
   localparam int COUNT_WIDTH_DEF = 32;

   localparam int KEY_W    = 64;
   localparam int TIME_W   = 32;
   localparam int SUM_W    = 35;
   localparam int PERIOD_W = 12;

   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 12'd10;

   typedef struct packed {
      logic [KEY_W-1:0]  word_key;
      logic [TIME_W-1:0] now_seconds;
   } req_type;

   typedef struct packed {
      logic [KEY_W-1:0] out_key;
      logic [SUM_W-1:0] window_sum;
      logic             last_of_emit;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_ALLOC,
      ST_INC_RD,
      ST_INC_WR,
      ST_CHECK,
      ST_EMIT_RD,
      ST_EMIT_WAIT,
      ST_EMIT_OUT
   } seq_state_type;

endpackage

/* rtl/rwkc_ram.sv */
// ----------------------------------------------------------------------------
// rwkc_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module rwkc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/rwkc_seq.sv */
// ----------------------------------------------------------------------------
// rwkc_seq
// Sequencer: key search, entry allocation, count update and emit walk.
// ----------------------------------------------------------------------------
module rwkc_seq #(
   parameter int  ENTRIES     = rwkc_pkg::ENTRIES_DEF,
   parameter int  CHUNKS      = rwkc_pkg::CHUNKS_DEF,
   parameter int  COUNT_WIDTH = rwkc_pkg::COUNT_WIDTH_DEF,
   localparam int IW          = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
   localparam int UW          = $clog2(ENTRIES + 1),
   localparam int CW          = $clog2(CHUNKS),
   localparam int CAW         = IW + CW
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  rwkc_pkg::req_type                   req_data,
   input  logic [rwkc_pkg::PERIOD_W-1:0]       period,
   input  logic                                out_free,
   output logic                                rsp_load,
   output rwkc_pkg::rsp_type                   rsp_beat,
   output logic                                key_wr_en,
   output logic [IW-1:0]                       key_wr_addr,
   output logic [rwkc_pkg::KEY_W-1:0]          key_wr_data,
   output logic                                key_rd_en,
   output logic [IW-1:0]                       key_rd_addr,
   input  logic [rwkc_pkg::KEY_W-1:0]          key_rd_data,
   output logic                                cnt_wr_en,
   output logic [CAW-1:0]                      cnt_wr_addr,
   output logic [COUNT_WIDTH-1:0]              cnt_wr_data,
   output logic                                cnt_rd_en,
   output logic [CAW-1:0]                      cnt_rd_addr,
   input  logic [COUNT_WIDTH-1:0]              cnt_rd_data
);

   localparam int ACC_W = COUNT_WIDTH + 3;   // room for up to 8 chunks
   localparam int XW    = (ACC_W > rwkc_pkg::SUM_W) ? ACC_W : rwkc_pkg::SUM_W;
   localparam logic [rwkc_pkg::SUM_W-1:0] SUM_MAX = '1;

   rwkc_pkg::seq_state_type state_ff, state_in;

   logic [rwkc_pkg::KEY_W-1:0]  key_ff, key_in;
   logic [rwkc_pkg::TIME_W-1:0] now_ff, now_in;
   logic [rwkc_pkg::TIME_W-1:0] last_ff, last_in;
   logic [UW-1:0]               idx_ff, idx_in;
   logic [UW-1:0]               used_ff, used_in;
   logic [IW-1:0]               cmp_idx_ff, cmp_idx_in;
   logic [IW-1:0]               entry_ff, entry_in;
   logic [CW-1:0]               chunk_ff, chunk_in;
   logic [CW-1:0]               rd_chunk_ff, rd_chunk_in;
   logic [CW-1:0]               head_ff, head_in;
   logic [CW-1:0]               tail_ff, tail_in;
   logic                        key_vld_ff, key_vld_in;
   logic                        cnt_vld_ff, cnt_vld_in;
   logic [ACC_W-1:0]            acc_ff, acc_in;

   logic                        accept;
   logic                        hit;
   logic                        lookup_done;
   logic                        room;
   logic                        due;
   logic                        chunk_last;
   logic                        last_entry;
   logic                        advance;
   logic [XW-1:0]               acc_x;
   logic [rwkc_pkg::SUM_W-1:0]  sum_sat;
   logic [COUNT_WIDTH-1:0]      cnt_inc;

   assign accept      = req_valid && (state_ff == rwkc_pkg::ST_IDLE);
   assign hit         = key_vld_ff && (key_rd_data == key_ff);
   assign lookup_done = (idx_ff == used_ff);
   assign room        = (used_ff < UW'(ENTRIES));
   assign due         = ({1'b0, now_ff} >= ({1'b0, last_ff} + 33'(period)));
   assign chunk_last  = (chunk_ff == CW'(CHUNKS - 1));
   assign last_entry  = ((idx_ff + UW'(1)) == used_ff);
   assign advance     = ((state_ff == rwkc_pkg::ST_CHECK) && due && (used_ff == '0)) ||
                        ((state_ff == rwkc_pkg::ST_EMIT_OUT) && out_free && last_entry);

   assign acc_x   = XW'(acc_ff);
   assign sum_sat = (acc_x > XW'(SUM_MAX)) ? SUM_MAX : acc_x[rwkc_pkg::SUM_W-1:0];
   assign cnt_inc = (cnt_rd_data == '1) ? cnt_rd_data : cnt_rd_data + COUNT_WIDTH'(1);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rwkc_pkg::ST_IDLE: begin
            if (accept) state_in = rwkc_pkg::ST_LOOKUP;
         end
         rwkc_pkg::ST_LOOKUP: begin
            if (hit) begin
               state_in = rwkc_pkg::ST_INC_RD;
            end else if (lookup_done) begin
               state_in = room ? rwkc_pkg::ST_ALLOC : rwkc_pkg::ST_CHECK;
            end
         end
         rwkc_pkg::ST_ALLOC: begin
            if (chunk_last) state_in = rwkc_pkg::ST_CHECK;
         end
         rwkc_pkg::ST_INC_RD: state_in = rwkc_pkg::ST_INC_WR;
         rwkc_pkg::ST_INC_WR: state_in = rwkc_pkg::ST_CHECK;
         rwkc_pkg::ST_CHECK: begin
            if (due && (used_ff != '0)) state_in = rwkc_pkg::ST_EMIT_RD;
            else                        state_in = rwkc_pkg::ST_IDLE;
         end
         rwkc_pkg::ST_EMIT_RD: begin
            if (chunk_last) state_in = rwkc_pkg::ST_EMIT_WAIT;
         end
         rwkc_pkg::ST_EMIT_WAIT: state_in = rwkc_pkg::ST_EMIT_OUT;
         rwkc_pkg::ST_EMIT_OUT: begin
            if (out_free) state_in = last_entry ? rwkc_pkg::ST_IDLE : rwkc_pkg::ST_EMIT_RD;
         end
         default: state_in = rwkc_pkg::ST_IDLE;
      endcase
   end

   // memory strobes and handshake outputs
   always_comb begin
      req_stall   = (state_ff != rwkc_pkg::ST_IDLE);
      rsp_load    = 1'b0;
      rsp_beat    = '{out_key: key_rd_data, window_sum: sum_sat, last_of_emit: last_entry};
      key_wr_en   = 1'b0;
      key_wr_addr = used_ff[IW-1:0];
      key_wr_data = key_ff;
      key_rd_en   = 1'b0;
      key_rd_addr = idx_ff[IW-1:0];
      cnt_wr_en   = 1'b0;
      cnt_wr_addr = {used_ff[IW-1:0], chunk_ff};
      cnt_wr_data = '0;
      cnt_rd_en   = 1'b0;
      cnt_rd_addr = {idx_ff[IW-1:0], chunk_ff};
      unique case (state_ff)
         rwkc_pkg::ST_LOOKUP: begin
            key_rd_en = !hit && !lookup_done;
         end
         rwkc_pkg::ST_ALLOC: begin
            key_wr_en   = (chunk_ff == '0);
            cnt_wr_en   = 1'b1;
            // fresh entry: head chunk already holds this item's count
            cnt_wr_data = (chunk_ff == head_ff) ? COUNT_WIDTH'(1) : '0;
         end
         rwkc_pkg::ST_INC_RD: begin
            cnt_rd_en   = 1'b1;
            cnt_rd_addr = {entry_ff, head_ff};
         end
         rwkc_pkg::ST_INC_WR: begin
            cnt_wr_en   = 1'b1;
            cnt_wr_addr = {entry_ff, head_ff};
            cnt_wr_data = cnt_inc;
         end
         rwkc_pkg::ST_EMIT_RD, rwkc_pkg::ST_EMIT_WAIT: begin
            key_rd_en   = (state_ff == rwkc_pkg::ST_EMIT_RD) && (chunk_ff == '0);
            cnt_rd_en   = (state_ff == rwkc_pkg::ST_EMIT_RD);
            // clear tail chunk once its old value has been read out
            cnt_wr_en   = cnt_vld_ff && (rd_chunk_ff == tail_ff);
            cnt_wr_addr = {idx_ff[IW-1:0], tail_ff};
         end
         rwkc_pkg::ST_EMIT_OUT: begin
            rsp_load = out_free;
         end
         default: begin
         end
      endcase
   end

   // datapath next values
   always_comb begin
      key_in      = key_ff;
      now_in      = now_ff;
      last_in     = last_ff;
      idx_in      = idx_ff;
      used_in     = used_ff;
      cmp_idx_in  = cmp_idx_ff;
      entry_in    = entry_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      key_vld_in  = (state_ff == rwkc_pkg::ST_LOOKUP) && key_rd_en;
      cnt_vld_in  = (state_ff == rwkc_pkg::ST_EMIT_RD);
      rd_chunk_in = chunk_ff;
      chunk_in    = '0;
      acc_in      = cnt_vld_ff ? acc_ff + ACC_W'(cnt_rd_data) : acc_ff;

      if (accept) begin
         key_in = req_data.word_key;
         now_in = req_data.now_seconds;
         idx_in = '0;
      end
      if (key_vld_in) begin
         cmp_idx_in = idx_ff[IW-1:0];
         idx_in     = idx_ff + UW'(1);
      end
      if ((state_ff == rwkc_pkg::ST_LOOKUP) && hit) begin
         entry_in = cmp_idx_ff;
      end
      if (((state_ff == rwkc_pkg::ST_ALLOC) || (state_ff == rwkc_pkg::ST_EMIT_RD)) &&
          !chunk_last) begin
         chunk_in = chunk_ff + CW'(1);
      end
      if ((state_ff == rwkc_pkg::ST_ALLOC) && chunk_last) begin
         used_in = used_ff + UW'(1);
      end
      if ((state_ff == rwkc_pkg::ST_EMIT_RD) && (chunk_ff == '0)) begin
         acc_in = '0;
      end
      if ((state_ff == rwkc_pkg::ST_CHECK) && due) begin
         last_in = now_ff;
         idx_in  = '0;
      end
      if ((state_ff == rwkc_pkg::ST_EMIT_OUT) && out_free && !last_entry) begin
         idx_in = idx_ff + UW'(1);
      end
      if (advance) begin
         head_in = tail_ff;
         tail_in = (tail_ff == CW'(CHUNKS - 1)) ? '0 : tail_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= rwkc_pkg::ST_IDLE;
         used_ff    <= '0;
         head_ff    <= '0;
         tail_ff    <= CW'(1);
         last_ff    <= '0;
         key_vld_ff <= 1'b0;
         cnt_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         used_ff    <= used_in;
         head_ff    <= head_in;
         tail_ff    <= tail_in;
         last_ff    <= last_in;
         key_vld_ff <= key_vld_in;
         cnt_vld_ff <= cnt_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff      <= key_in;
      now_ff      <= now_in;
      idx_ff      <= idx_in;
      cmp_idx_ff  <= cmp_idx_in;
      entry_ff    <= entry_in;
      chunk_ff    <= chunk_in;
      rd_chunk_ff <= rd_chunk_in;
      acc_ff      <= acc_in;
   end

endmodule

/* rtl/rolling_window_key_counter.sv */
// ----------------------------------------------------------------------------
// rolling_window_key_counter
// Counts keys over a rolling window of time chunks and emits windowed sums.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one beat per counted word (hashed key, time in seconds).
//     req_stall is high while an item is being worked on; one item at a time.
//   rsp channel: one beat per table entry, in insertion order, only when an
//     item's time reaches last emit time plus the period; last_of_emit marks
//     the final beat of a burst.
//   csr port: csr_wr_en/csr_wr_data write the emit period; write only while
//     the block is idle.
// Steps per item: accept, then the key search (one key RAM read per stored
//   entry, each compared in the cycle after its read), then one count write
//   per chunk for a new entry or a count read and write for an update, then
//   the emit check. A new key with the table full is not counted.
// Emit: per entry, one count RAM read per chunk, a read wait, then output.
// Reset: table empty, head chunk 0, tail chunk 1, last emit time 0,
//   period 10. The RAMs are not cleared; entries are written before use.
// Receiver stall: the emit walk holds at its result stage until the output
//   register frees; the last beat may wait there while a new item starts.
// ----------------------------------------------------------------------------
module rolling_window_key_counter #(
   parameter int ENTRIES     = rwkc_pkg::ENTRIES_DEF,
   parameter int CHUNKS      = rwkc_pkg::CHUNKS_DEF,
   parameter int COUNT_WIDTH = rwkc_pkg::COUNT_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  rwkc_pkg::req_type             req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output rwkc_pkg::rsp_type             rsp_data,
   input  logic                          csr_wr_en,
   input  logic [rwkc_pkg::PERIOD_W-1:0] csr_wr_data
);

   localparam int IW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CW  = $clog2(CHUNKS);
   localparam int CAW = IW + CW;

   // period register
   logic [rwkc_pkg::PERIOD_W-1:0] period_ff, period_in;

   // output register between the emit walk and the receiver
   logic              rsp_valid_ff, rsp_valid_in;
   rwkc_pkg::rsp_type rsp_data_ff, rsp_data_in;
   logic              out_free;
   logic              rsp_load;
   rwkc_pkg::rsp_type rsp_beat;

   // RAM ports
   logic                         key_wr_en;
   logic [IW-1:0]                key_wr_addr;
   logic [rwkc_pkg::KEY_W-1:0]   key_wr_data;
   logic                         key_rd_en;
   logic [IW-1:0]                key_rd_addr;
   logic [rwkc_pkg::KEY_W-1:0]   key_rd_data;
   logic                         cnt_wr_en;
   logic [CAW-1:0]               cnt_wr_addr;
   logic [COUNT_WIDTH-1:0]       cnt_wr_data;
   logic                         cnt_rd_en;
   logic [CAW-1:0]               cnt_rd_addr;
   logic [COUNT_WIDTH-1:0]       cnt_rd_data;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      period_in    = csr_wr_en ? csr_wr_data : period_ff;
      rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
      rsp_data_in  = rsp_load ? rsp_beat : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff    <= rwkc_pkg::PERIOD_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         period_ff    <= period_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // key table, one key per entry
   rwkc_ram #(
      .WIDTH (rwkc_pkg::KEY_W),
      .DEPTH (ENTRIES)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (key_wr_en),
      .wr_addr (key_wr_addr),
      .wr_data (key_wr_data),
      .rd_en   (key_rd_en),
      .rd_addr (key_rd_addr),
      .rd_data (key_rd_data)
   );

   // chunk counts, addressed {entry, chunk}
   rwkc_ram #(
      .WIDTH (COUNT_WIDTH),
      .DEPTH (2 ** CAW)
   ) u_cnt_ram (
      .clock   (clock),
      .wr_en   (cnt_wr_en),
      .wr_addr (cnt_wr_addr),
      .wr_data (cnt_wr_data),
      .rd_en   (cnt_rd_en),
      .rd_addr (cnt_rd_addr),
      .rd_data (cnt_rd_data)
   );

   rwkc_seq #(
      .ENTRIES     (ENTRIES),
      .CHUNKS      (CHUNKS),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .period      (period_ff),
      .out_free    (out_free),
      .rsp_load    (rsp_load),
      .rsp_beat    (rsp_beat),
      .key_wr_en   (key_wr_en),
      .key_wr_addr (key_wr_addr),
      .key_wr_data (key_wr_data),
      .key_rd_en   (key_rd_en),
      .key_rd_addr (key_rd_addr),
      .key_rd_data (key_rd_data),
      .cnt_wr_en   (cnt_wr_en),
      .cnt_wr_addr (cnt_wr_addr),
      .cnt_wr_data (cnt_wr_data),
      .cnt_rd_en   (cnt_rd_en),
      .cnt_rd_addr (cnt_rd_addr),
      .cnt_rd_data (cnt_rd_data)
   );

endmodule
